// File: rtl/fractal_adaptive_moving_average_assert.svh
// Assertion macros used by the fractal adaptive moving average controller.
`ifndef FRACTAL_ADAPTIVE_MOVING_AVERAGE_ASSERT_SVH
`define FRACTAL_ADAPTIVE_MOVING_AVERAGE_ASSERT_SVH

// Same-cycle implication, clocked on clk_i and disabled while rst_ni is low.
`define FRAMA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and disabled while rst_ni is low.
`define FRAMA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/frama_pkg.sv
// Shared constants, types and command codes of the fractal adaptive moving average.
`default_nettype none
package frama_pkg;

  localparam int unsigned PERIOD     = 16;
  localparam int unsigned HALF       = PERIOD / 2;
  localparam int unsigned RING_W     = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int unsigned BARS_W     = $clog2(PERIOD + 1);
  localparam int unsigned CNT_W      = $clog2(HALF + 33);
  localparam int unsigned PRICE_W    = 32;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned XW         = 34 + BARS_W;
  localparam int unsigned EW         = $clog2(XW);
  localparam int unsigned LW         = EW + 16;
  localparam int unsigned PW         = COEF_W + LW + 2;
  localparam int unsigned TW         = PW + 17 - 28;
  localparam int unsigned NW         = TW - 16;
  localparam int unsigned SHW        = NW + 1;
  localparam int unsigned ALPHA_W    = 17;
  localparam int unsigned ONE_Q16    = 65536;
  localparam int unsigned LOG2E_Q16  = 94548;
  localparam int unsigned LOG_STEPS  = 16;
  localparam int unsigned POW_BITS   = 16;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned PADDR_W    = 3;

  localparam logic REG_COEF = 1'b0;
  localparam logic [COEF_W-1:0] COEF_RESET = 16'hB666;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_WARM, OP_NORM_INIT, OP_NORM, OP_LOG_SQ, OP_LOG_SAVE,
    OP_DIM, OP_TMAG, OP_POW_INIT, OP_ROOT_INIT, OP_ROOT_STEP, OP_ROOT_END,
    OP_ALPHA, OP_MUL_A, OP_MUL_B, OP_SUM, OP_RING_RD, OP_RING_WR, OP_SCAN, OP_EMIT
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_WARM, ST_CHECK, ST_NORM_A, ST_SQ_A, ST_LOG_A, ST_NORM_B, ST_SQ_B,
    ST_DIM, ST_TMAG, ST_POW_INIT, ST_ROOT_INIT, ST_ROOT, ST_ROOT_END, ST_ALPHA,
    ST_MUL_A, ST_MUL_B, ST_SUM, ST_RING_RD, ST_RING_WR, ST_SCAN, ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e           op;
    logic [CNT_W-1:0] cnt;
    logic [3:0]       bitn;
  } dp_cmd_t;

  typedef struct packed {
    logic warm;
    logic r3_pos;
    logic rs_pos;
    logic norm_done;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/frama_if.sv
// Request channel interfaces for bars in and averages out.
`default_nettype none
interface frama_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] close_price;
  logic [31:0] low_price;
  logic [31:0] high_price;
  modport source (output valid, close_price, low_price, high_price, input ready);
  modport sink (input valid, close_price, low_price, high_price, output ready);
endinterface

interface frama_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] average_value;
  logic        warming_up;
  modport source (output valid, average_value, warming_up, input ready);
  modport sink (input valid, average_value, warming_up, output ready);
endinterface
`default_nettype wire

// File: rtl/frama_dp.sv
// Datapath: window stores, extremes, log2, exp, square root and average arithmetic.
`default_nettype none
module frama_dp (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire frama_pkg::dp_cmd_t       cmd_i,
  output frama_pkg::dp_stat_t           stat_o,
  input  wire logic signed [15:0]       coef_i,
  input  wire logic [31:0]              close_i,
  input  wire logic [31:0]              low_i,
  input  wire logic [31:0]              high_i,
  output logic [31:0]                   avg_o,
  output logic                          warm_o
);
  import frama_pkg::*;

  logic [PRICE_W-1:0] ext_q [4];
  logic [PRICE_W-1:0] ext_d [4];
  logic [BARS_W-1:0]  bars_q, bars_d;
  logic [RING_W-1:0]  ring_q, ring_d;
  logic [PRICE_W-1:0] prev_q, prev_d;

  logic [PRICE_W-1:0] close_q, low_q, high_q;
  logic [31:0]        r3_q;
  logic [32:0]        rs_q;
  logic               r3_pos_q, rs_pos_q;
  logic [XW-1:0]      m_q;
  logic [EW-1:0]      e_q;
  logic [15:0]        frac_q;
  logic [LW-1:0]      la_q;
  logic signed [PW-1:0] prod_q;
  logic               pos_q;
  logic [NW-1:0]      n_q;
  logic [15:0]        f_q, pf_q;
  logic [SHW-1:0]     sh_q;
  logic [32:0]        y_q;
  logic [63:0]        v_q, r_q, b_q;
  logic [ALPHA_W-1:0] alpha_q;
  logic [48:0]        p1_q;
  logic signed [50:0] p2_q;
  logic [PRICE_W-1:0] res_avg_q, out_avg_q;
  logic               res_warm_q, out_warm_q;

  logic [63:0] old_mem [HALF];
  logic [63:0] new_mem [HALF];
  logic [63:0] rd_old_q, rd_new_q;
  logic        old_we, new_we;
  logic [RING_W-1:0] old_wa, new_wa, rd_a;
  logic [63:0] old_wd, new_wd;

  logic [PRICE_W-1:0] hmax, lmin;
  logic signed [32:0] r3;
  logic signed [33:0] rs;
  logic [63:0]        sq;
  logic [33:0]        m2;
  logic [LW-1:0]      lb;
  logic signed [LW:0] dd;
  logic signed [LW+1:0] dsel, dm1;
  logic signed [PW-1:0] prod;
  logic [PW-1:0]      mag;
  logic [PW+16:0]     tprod;
  logic [TW-1:0]      tmag;
  logic [32:0]        y1;
  logic [63:0]        rb;
  logic               ge;
  logic [32:0]        yshift;
  logic [ALPHA_W-1:0] alpha;
  logic signed [17:0] wgt;
  logic signed [51:0] acc;
  logic [PRICE_W-1:0] avg;
  logic [BARS_W-1:0]  kk;
  logic [CNT_W-1:0]   scan_i;

  always_comb begin
    hmax = (ext_q[0] > ext_q[1]) ? ext_q[0] : ext_q[1];
    lmin = (ext_q[2] < ext_q[3]) ? ext_q[2] : ext_q[3];
    r3 = $signed({1'b0, hmax}) - $signed({1'b0, lmin});
    rs = ($signed({2'b0, ext_q[0]}) - $signed({2'b0, ext_q[2]}))
       + ($signed({2'b0, ext_q[1]}) - $signed({2'b0, ext_q[3]}));
    sq = {32'd0, m_q[31:0]} * {32'd0, m_q[31:0]};
    m2 = sq[63:30];
    lb = {e_q, frac_q};
    dd = $signed({1'b0, la_q}) - $signed({1'b0, lb});
    dsel = (dd <= 0) ? (LW+2)'(ONE_Q16) : {dd[LW], dd};
    dm1 = dsel - $signed((LW+2)'(ONE_Q16));
    prod = $signed(coef_i) * dm1;
    mag = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
    tprod = {17'd0, mag} * (PW+17)'(LOG2E_Q16);
    tmag = tprod[PW+16:28];
    y1 = pf_q[cmd_i.bitn] ? {y_q[31:0], 1'b0} : y_q;
    rb = r_q + b_q;
    ge = (v_q >= rb);
    yshift = y_q >> sh_q[5:0];
    if (!r3_pos_q) begin
      alpha = '0;
    end else if (!rs_pos_q) begin
      alpha = ALPHA_W'(ONE_Q16);
    end else if (pos_q && (n_q != '0)) begin
      alpha = '1;
    end else if (sh_q > SHW'(63)) begin
      alpha = '0;
    end else begin
      alpha = yshift[ALPHA_W-1:0];
    end
    wgt = $signed(18'(ONE_Q16)) - $signed({1'b0, alpha_q});
    acc = $signed({3'b0, p1_q}) + $signed({p2_q[50], p2_q});
    if (acc < 0) begin
      avg = '0;
    end else if (acc[51:48] != 4'd0) begin
      avg = '1;
    end else begin
      avg = acc[47:16];
    end
    kk = bars_q - BARS_W'(PERIOD - HALF);
    scan_i = (cmd_i.cnt == CNT_W'(HALF)) ? '0 : cmd_i.cnt;
  end

  always_comb begin
    old_we = 1'b0;
    new_we = 1'b0;
    old_wa = ring_q;
    new_wa = ring_q;
    old_wd = rd_new_q;
    new_wd = {high_q, low_q};
    rd_a = '0;
    case (cmd_i.op)
      OP_WARM: begin
        old_we = (bars_q < BARS_W'(HALF));
        new_we = (bars_q >= BARS_W'(PERIOD - HALF));
        old_wa = bars_q[RING_W-1:0];
        new_wa = kk[RING_W-1:0];
        old_wd = {high_q, low_q};
      end
      OP_RING_RD: rd_a = ring_q;
      OP_RING_WR: begin
        old_we = 1'b1;
        new_we = 1'b1;
      end
      OP_SCAN: rd_a = scan_i[RING_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (old_we) begin
      old_mem[old_wa] <= old_wd;
    end
    if (new_we) begin
      new_mem[new_wa] <= new_wd;
    end
    rd_old_q <= old_mem[rd_a];
    rd_new_q <= new_mem[rd_a];
  end

  always_comb begin
    ext_d = ext_q;
    bars_d = bars_q;
    ring_d = ring_q;
    prev_d = prev_q;
    case (cmd_i.op)
      OP_WARM: begin
        if (bars_q < BARS_W'(HALF)) begin
          if ((bars_q == '0) || (high_q > ext_q[0])) ext_d[0] = high_q;
          if ((bars_q == '0) || (low_q < ext_q[2])) ext_d[2] = low_q;
        end
        if (bars_q >= BARS_W'(PERIOD - HALF)) begin
          if ((kk == '0) || (high_q > ext_q[1])) ext_d[1] = high_q;
          if ((kk == '0) || (low_q < ext_q[3])) ext_d[3] = low_q;
        end
        bars_d = bars_q + 1'b1;
        ring_d = '0;
        prev_d = close_q;
      end
      OP_SUM: prev_d = avg;
      OP_RING_WR: begin
        ext_d[0] = '0;
        ext_d[1] = '0;
        ext_d[2] = '1;
        ext_d[3] = '1;
        ring_d = (ring_q == RING_W'(HALF - 1)) ? '0 : ring_q + 1'b1;
      end
      OP_SCAN: begin
        if (cmd_i.cnt != '0) begin
          if (rd_old_q[63:32] > ext_q[0]) ext_d[0] = rd_old_q[63:32];
          if (rd_new_q[63:32] > ext_q[1]) ext_d[1] = rd_new_q[63:32];
          if (rd_old_q[31:0] < ext_q[2]) ext_d[2] = rd_old_q[31:0];
          if (rd_new_q[31:0] < ext_q[3]) ext_d[3] = rd_new_q[31:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q[0] <= '0;
      ext_q[1] <= '0;
      ext_q[2] <= '0;
      ext_q[3] <= '0;
      bars_q <= '0;
      ring_q <= '0;
      prev_q <= '0;
    end else begin
      ext_q <= ext_d;
      bars_q <= bars_d;
      ring_q <= ring_d;
      prev_q <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        close_q <= close_i;
        low_q <= low_i;
        high_q <= high_i;
        r3_q <= r3[31:0];
        rs_q <= rs[32:0];
        r3_pos_q <= !r3[32] && (r3 != '0);
        rs_pos_q <= !rs[33] && (rs != '0);
      end
      OP_WARM: begin
        res_avg_q <= close_q;
        res_warm_q <= 1'b1;
      end
      OP_NORM_INIT: begin
        m_q <= XW'(rs_q) * XW'(PERIOD);
        e_q <= EW'(30);
        frac_q <= '0;
      end
      OP_NORM: begin
        if (m_q[XW-1:31] != '0) begin
          m_q <= m_q >> 1;
          e_q <= e_q + 1'b1;
        end else begin
          m_q <= m_q << 1;
          e_q <= e_q - 1'b1;
        end
      end
      OP_LOG_SQ: begin
        if (m2[31]) begin
          m_q <= XW'(m2[33:1]);
          frac_q <= {frac_q[14:0], 1'b1};
        end else begin
          m_q <= XW'(m2);
          frac_q <= {frac_q[14:0], 1'b0};
        end
      end
      OP_LOG_SAVE: begin
        la_q <= lb;
        m_q <= XW'(r3_q) * XW'(HALF);
        e_q <= EW'(30);
        frac_q <= '0;
      end
      OP_DIM: prod_q <= prod;
      OP_TMAG: begin
        pos_q <= !prod_q[PW-1];
        n_q <= tmag[TW-1:16];
        f_q <= tmag[15:0];
      end
      OP_POW_INIT: begin
        y_q <= 33'(1) << 30;
        if (pos_q || (f_q == '0)) begin
          pf_q <= f_q;
        end else begin
          pf_q <= 16'(~f_q + 1'b1);
        end
        if (pos_q) begin
          sh_q <= SHW'(14);
        end else if (f_q == '0) begin
          sh_q <= SHW'(14) + SHW'(n_q);
        end else begin
          sh_q <= SHW'(15) + SHW'(n_q);
        end
      end
      OP_ROOT_INIT: begin
        v_q <= {1'b0, y1, 30'd0};
        r_q <= '0;
        b_q <= 64'(1) << 62;
      end
      OP_ROOT_STEP: begin
        if (ge) begin
          v_q <= v_q - rb;
          r_q <= (r_q >> 1) + b_q;
        end else begin
          r_q <= r_q >> 1;
        end
        b_q <= b_q >> 2;
      end
      OP_ROOT_END: y_q <= r_q[32:0];
      OP_ALPHA: alpha_q <= alpha;
      OP_MUL_A: p1_q <= {32'd0, alpha_q} * {17'd0, close_q};
      OP_MUL_B: p2_q <= wgt * $signed({1'b0, prev_q});
      OP_SUM: begin
        res_avg_q <= avg;
        res_warm_q <= 1'b0;
      end
      OP_EMIT: begin
        out_avg_q <= res_avg_q;
        out_warm_q <= res_warm_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o.warm = (bars_q < BARS_W'(PERIOD));
    stat_o.r3_pos = r3_pos_q;
    stat_o.rs_pos = rs_pos_q;
    stat_o.norm_done = (m_q[XW-1:31] == '0) && m_q[30];
  end

  assign avg_o = out_avg_q;
  assign warm_o = out_warm_q;

endmodule
`default_nettype wire

// File: rtl/frama_ctrl.sv
// Controller: sequences one bar through the datapath and owns the output valid.
`default_nettype none
module frama_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_vld_i,
  output logic                      in_rdy_o,
  output logic                      out_vld_o,
  input  wire logic                 out_rdy_i,
  input  wire frama_pkg::dp_stat_t  stat_i,
  output frama_pkg::dp_cmd_t        cmd_o
);
  import frama_pkg::*;

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [3:0]       bit_q, bit_d;
  logic             out_vld_q, out_vld_d;
  logic             emit;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_vld_i) state_d = stat_i.warm ? ST_WARM : ST_CHECK;
      ST_WARM: state_d = ST_FIN;
      ST_CHECK: state_d = (stat_i.r3_pos && stat_i.rs_pos) ? ST_NORM_A : ST_ALPHA;
      ST_NORM_A: if (stat_i.norm_done) state_d = ST_SQ_A;
      ST_SQ_A: if (cnt_q == CNT_W'(LOG_STEPS - 1)) state_d = ST_LOG_A;
      ST_LOG_A: state_d = ST_NORM_B;
      ST_NORM_B: if (stat_i.norm_done) state_d = ST_SQ_B;
      ST_SQ_B: if (cnt_q == CNT_W'(LOG_STEPS - 1)) state_d = ST_DIM;
      ST_DIM: state_d = ST_TMAG;
      ST_TMAG: state_d = ST_POW_INIT;
      ST_POW_INIT: state_d = ST_ROOT_INIT;
      ST_ROOT_INIT: state_d = ST_ROOT;
      ST_ROOT: if (cnt_q == CNT_W'(SQRT_STEPS - 1)) state_d = ST_ROOT_END;
      ST_ROOT_END: state_d = (bit_q == 4'(POW_BITS - 1)) ? ST_ALPHA : ST_ROOT_INIT;
      ST_ALPHA: state_d = ST_MUL_A;
      ST_MUL_A: state_d = ST_MUL_B;
      ST_MUL_B: state_d = ST_SUM;
      ST_SUM: state_d = ST_RING_RD;
      ST_RING_RD: state_d = ST_RING_WR;
      ST_RING_WR: state_d = ST_SCAN;
      ST_SCAN: if (cnt_q == CNT_W'(HALF)) state_d = ST_FIN;
      ST_FIN: if (!out_vld_q || out_rdy_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d = (state_d != state_q) ? '0 : cnt_q + 1'b1;
    bit_d = bit_q;
    if (state_q == ST_POW_INIT) begin
      bit_d = '0;
    end else if ((state_q == ST_ROOT_END) && (bit_q != 4'(POW_BITS - 1))) begin
      bit_d = bit_q + 1'b1;
    end
  end

  always_comb begin
    cmd_o.op = OP_NONE;
    cmd_o.cnt = cnt_q;
    cmd_o.bitn = bit_q;
    in_rdy_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_rdy_o = 1'b1;
        if (in_vld_i) cmd_o.op = OP_LOAD;
      end
      ST_WARM: cmd_o.op = OP_WARM;
      ST_CHECK: if (stat_i.r3_pos && stat_i.rs_pos) cmd_o.op = OP_NORM_INIT;
      ST_NORM_A, ST_NORM_B: if (!stat_i.norm_done) cmd_o.op = OP_NORM;
      ST_SQ_A, ST_SQ_B: cmd_o.op = OP_LOG_SQ;
      ST_LOG_A: cmd_o.op = OP_LOG_SAVE;
      ST_DIM: cmd_o.op = OP_DIM;
      ST_TMAG: cmd_o.op = OP_TMAG;
      ST_POW_INIT: cmd_o.op = OP_POW_INIT;
      ST_ROOT_INIT: cmd_o.op = OP_ROOT_INIT;
      ST_ROOT: cmd_o.op = OP_ROOT_STEP;
      ST_ROOT_END: cmd_o.op = OP_ROOT_END;
      ST_ALPHA: cmd_o.op = OP_ALPHA;
      ST_MUL_A: cmd_o.op = OP_MUL_A;
      ST_MUL_B: cmd_o.op = OP_MUL_B;
      ST_SUM: cmd_o.op = OP_SUM;
      ST_RING_RD: cmd_o.op = OP_RING_RD;
      ST_RING_WR: cmd_o.op = OP_RING_WR;
      ST_SCAN: cmd_o.op = OP_SCAN;
      ST_FIN: if (!out_vld_q || out_rdy_i) cmd_o.op = OP_EMIT;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  assign emit = (cmd_o.op == OP_EMIT);
  assign out_vld_d = emit ? 1'b1 : (out_rdy_i ? 1'b0 : out_vld_q);
  assign out_vld_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      bit_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      bit_q <= bit_d;
      out_vld_q <= out_vld_d;
    end
  end

`include "fractal_adaptive_moving_average_assert.svh"
`FRAMA_ASSERT_IMP(a_emit_free, emit, !out_vld_q || out_rdy_i, "result emitted over a pending one")
`FRAMA_ASSERT_NXT(a_accept_next, in_vld_i && in_rdy_o, state_q == ST_WARM || state_q == ST_CHECK, "bad state after request")
`FRAMA_ASSERT_IMP(a_root_cnt, state_q == ST_ROOT, cnt_q < CNT_W'(SQRT_STEPS), "square root step count overrun")

endmodule
`default_nettype wire

// File: rtl/fractal_adaptive_moving_average.sv
// Top level of the fractal adaptive moving average with its configuration port.
//
//   channel  direction  content
//   in_i     sink       close_price, low_price, high_price (Q16.16)
//   out_o    source     average_value (Q16.16), warming_up
//   apb      slave      alpha_coefficient at byte address 0
//
// A warm-up bar passes through the request, the window update and the
// hand-off to the output register.
// A steady bar runs two log2 normalizations of up to 26 and 27 steps plus
// 16 squarings each, 16 bit-serial square roots and a rescan of HALF ring
// entries; the square root loop dominates.
// A bar with a zero or inverted window range or a nonpositive half-range sum skips
// the log2 and exp work.
// Reset is asynchronous and clears the extremes, the average and the counters.
// A new request is taken while a finished result waits in the output register.
`default_nettype none
module fractal_adaptive_moving_average (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  frama_in_if.sink                  in_i,
  frama_out_if.source               out_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import frama_pkg::*;

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [COEF_W-1:0]  coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= COEF_RESET;
    end else if (psel && penable && pwrite && (paddr[PADDR_W-1] == REG_COEF)) begin
      coef_q <= pwdata[COEF_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_COEF) ? {{16{coef_q[COEF_W-1]}}, coef_q} : '0;

  frama_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (in_i.valid),
    .in_rdy_o  (in_i.ready),
    .out_vld_o (out_o.valid),
    .out_rdy_i (out_o.ready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  frama_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .coef_i  ($signed(coef_q)),
    .close_i (in_i.close_price),
    .low_i   (in_i.low_price),
    .high_i  (in_i.high_price),
    .avg_o   (out_o.average_value),
    .warm_o  (out_o.warming_up)
  );

endmodule
`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the fractal adaptive moving average: bars in, averages checked.
`default_nettype none
module testbench;
  import frama_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned RANDOM_BARS = 830;
  localparam int unsigned SETTLE = 800;

  typedef struct packed {
    logic [31:0] close_price;
    logic [31:0] low_price;
    logic [31:0] high_price;
    logic        typed;
    logic [31:0] avg;
  } bar_row_t;

  typedef struct packed {
    logic [31:0] avg;
    logic        warm;
  } average_t;

  // During warm-up the close is passed through unchanged.
  localparam bar_row_t DIRECTED_BARS [24] = '{
    '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
    '{32'h5555_5555, 32'h5555_0000, 32'h5555_FFFF, 1'b1, 32'h5555_5555},
    '{32'hAAAA_AAAA, 32'hAAAA_0000, 32'hAAAA_FFFF, 1'b1, 32'hAAAA_AAAA},
    '{32'h0001_0000, 32'h0000_8000, 32'h0001_8000, 1'b1, 32'h0001_0000},
    '{32'h0064_0000, 32'h0063_0000, 32'h0065_0000, 1'b1, 32'h0064_0000},
    '{32'h0064_8000, 32'h0064_0000, 32'h0066_0000, 1'b1, 32'h0064_8000},
    '{32'h0065_0000, 32'h0064_0000, 32'h0067_0000, 1'b1, 32'h0065_0000},
    '{32'h0066_0000, 32'h0065_0000, 32'h0068_0000, 1'b1, 32'h0066_0000},
    '{32'h0067_0000, 32'h0066_0000, 32'h0068_0000, 1'b1, 32'h0067_0000},
    '{32'h0065_0000, 32'h0064_0000, 32'h0066_0000, 1'b1, 32'h0065_0000},
    '{32'h0064_0000, 32'h0063_0000, 32'h0065_0000, 1'b1, 32'h0064_0000},
    '{32'h0063_0000, 32'h0062_0000, 32'h0064_0000, 1'b1, 32'h0063_0000},
    '{32'h0062_0000, 32'h0061_0000, 32'h0063_0000, 1'b1, 32'h0062_0000},
    '{32'h0061_0000, 32'h0060_0000, 32'h0062_0000, 1'b1, 32'h0061_0000},
    '{32'h0060_0000, 32'h005F_0000, 32'h0061_0000, 1'b1, 32'h0060_0000},
    '{32'h0070_0000, 32'h006F_0000, 32'h0071_0000, 1'b0, 32'h0},
    '{32'h0080_0000, 32'h0070_0000, 32'h0090_0000, 1'b0, 32'h0},
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{32'h0050_0000, 32'h0060_0000, 32'h0040_0000, 1'b0, 32'h0},
    '{32'h0064_0000, 32'h0064_0000, 32'h0064_0000, 1'b0, 32'h0},
    '{32'h0064_0000, 32'h0064_0000, 32'h0064_0000, 1'b0, 32'h0},
    '{32'h0064_0000, 32'h0064_0000, 32'h0064_0000, 1'b0, 32'h0}
  };

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  frama_in_if bar_if ();
  frama_out_if avg_if ();

  fractal_adaptive_moving_average dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(bar_if), .out_o(avg_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  longint unsigned older_highs [HALF];
  longint unsigned newer_highs [HALF];
  longint unsigned older_lows [HALF];
  longint unsigned newer_lows [HALF];
  longint unsigned half_ext [4];
  longint unsigned last_average;
  int unsigned bar_count, ring_pos;
  longint coefficient;

  average_t pending_averages [$];
  logic [31:0] typed_averages [$];
  logic typed_flags [$];
  int unsigned mismatches, results_seen, held_seen, cycles;
  int unsigned bars_sent;

  function automatic longint unsigned log2_fix(longint unsigned x);
    int unsigned e;
    longint unsigned t, m, frac;
    e = 0;
    t = x;
    frac = 0;
    while (t > 1) begin
      t >>= 1;
      e++;
    end
    m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac <<= 1;
      if (m >= (64'd1 << 31)) begin
        frac |= 1;
        m >>= 1;
      end
    end
    return (longint'(e) << 16) | frac;
  endfunction

  function automatic longint unsigned root_fix(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned pow2_frac(longint unsigned f);
    longint unsigned y;
    y = 64'd1 << 30;
    for (int i = 0; i < 16; i++) begin
      if ((f >> i) & 1) y <<= 1;
      y = root_fix(y << 30);
    end
    return y;
  endfunction

  function automatic longint unsigned alpha_fix();
    longint h1, h2, l1, l2, r3, rs, d, prod;
    longint unsigned mag, tmag, n, f, sh;
    h1 = half_ext[0];
    h2 = half_ext[1];
    l1 = half_ext[2];
    l2 = half_ext[3];
    r3 = (h1 > h2 ? h1 : h2) - (l1 < l2 ? l1 : l2);
    rs = (h1 - l1) + (h2 - l2);
    if (r3 <= 0) return 0;
    if (rs <= 0) return ONE_Q16;
    d = longint'(log2_fix(rs * PERIOD)) - longint'(log2_fix(r3 * HALF));
    if (d <= 0) d = ONE_Q16;
    prod = coefficient * (d - ONE_Q16);
    mag = (prod < 0) ? -prod : prod;
    tmag = (mag * LOG2E_Q16) >> 28;
    n = tmag >> 16;
    f = tmag & 16'hFFFF;
    if (prod >= 0) begin
      if (n >= 1) return 17'h1FFFF;
      return pow2_frac(f) >> 14;
    end
    if (f == 0) begin
      sh = 14 + n;
    end else begin
      sh = 15 + n;
      f = ONE_Q16 - f;
    end
    if (sh > 63) return 0;
    return pow2_frac(f) >> sh;
  endfunction

  function automatic average_t predict_average(logic [31:0] c, logic [31:0] l, logic [31:0] h);
    average_t res;
    int unsigned n, k, p;
    longint unsigned alpha, mx0, mx1, mn0, mn1;
    longint acc;
    if (bar_count < PERIOD) begin
      n = bar_count;
      if (n < HALF) begin
        older_highs[n] = h;
        older_lows[n] = l;
        if (n == 0 || h > half_ext[0]) half_ext[0] = h;
        if (n == 0 || l < half_ext[2]) half_ext[2] = l;
      end
      if (n >= PERIOD - HALF) begin
        k = n - (PERIOD - HALF);
        newer_highs[k] = h;
        newer_lows[k] = l;
        if (k == 0 || h > half_ext[1]) half_ext[1] = h;
        if (k == 0 || l < half_ext[3]) half_ext[3] = l;
      end
      bar_count++;
      ring_pos = 0;
      last_average = c;
      res.avg = c;
      res.warm = 1'b1;
      return res;
    end
    alpha = alpha_fix();
    acc = longint'(alpha * c) + (longint'(ONE_Q16) - longint'(alpha)) * longint'(last_average);
    if (acc < 0) res.avg = '0;
    else if ((acc >>> 16) > 64'hFFFF_FFFF) res.avg = 32'hFFFF_FFFF;
    else res.avg = 32'(acc >>> 16);
    p = ring_pos % HALF;
    older_highs[p] = newer_highs[p];
    newer_highs[p] = h;
    older_lows[p] = newer_lows[p];
    newer_lows[p] = l;
    mx0 = older_highs[0];
    mx1 = newer_highs[0];
    mn0 = older_lows[0];
    mn1 = newer_lows[0];
    for (int i = 1; i < HALF; i++) begin
      if (older_highs[i] > mx0) mx0 = older_highs[i];
      if (newer_highs[i] > mx1) mx1 = newer_highs[i];
      if (older_lows[i] < mn0) mn0 = older_lows[i];
      if (newer_lows[i] < mn1) mn1 = newer_lows[i];
    end
    half_ext = '{mx0, mx1, mn0, mn1};
    ring_pos = (p + 1) % HALF;
    if (res.avg == last_average[31:0]) held_seen++;
    last_average = res.avg;
    res.warm = 1'b0;
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("[fractal_adaptive_moving_average] ERROR");
        $finish;
      end
    end
  end

  // Result side: random backpressure, with calm stretches.
  initial begin
    average_t want;
    logic typed;
    logic [31:0] typed_avg;
    int unsigned hold;
    avg_if.ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && avg_if.valid && avg_if.ready) begin
        results_seen++;
        if (pending_averages.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", avg_if.average_value);
        end else begin
          want = pending_averages.pop_front();
          typed = typed_flags.pop_front();
          typed_avg = typed_averages.pop_front();
          if (typed && typed_avg != want.avg) begin
            mismatches++;
            if (mismatches <= 10)
              $display("predictor disagrees with table: %h vs %h", want.avg, typed_avg);
          end
          if (avg_if.average_value !== want.avg || avg_if.warming_up !== want.warm) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected avg %h warm %b, got avg %h warm %b",
                       results_seen, want.avg, want.warm,
                       avg_if.average_value, avg_if.warming_up);
          end
        end
      end
      if (hold > 0) begin
        hold--;
        avg_if.ready <= 1'b0;
      end else if ((cycles / 5000) % 4 == 3) begin
        avg_if.ready <= 1'b1;
      end else begin
        hold = pick_gap();
        avg_if.ready <= (hold == 0);
      end
    end
  end

  task automatic write_coefficient(logic [15:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_COEF, 2'b00};
    pwdata <= {{16{value[15]}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    coefficient = longint'(signed'(value));
  endtask

  task automatic wait_idle();
    while (pending_averages.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic send_bar(logic [31:0] c, logic [31:0] l, logic [31:0] h,
                          logic typed, logic [31:0] typed_avg, bit calm);
    int unsigned gap;
    bar_if.valid <= 1'b1;
    bar_if.close_price <= c;
    bar_if.low_price <= l;
    bar_if.high_price <= h;
    do @(posedge clk_i); while (!bar_if.ready);
    bars_sent++;
    pending_averages.push_back(predict_average(c, l, h));
    typed_flags.push_back(typed);
    typed_averages.push_back(typed_avg);
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      bar_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    logic [15:0] coef_plan [5];
    logic [31:0] base, c, l, h, spread;
    int unsigned mode;
    bit calm;
    coef_plan = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0000, COEF_RESET};
    coef_plan[3] = 16'($urandom_range(16'hFFFF));
    mismatches = 0;
    results_seen = 0;
    held_seen = 0;
    bars_sent = 0;
    bar_count = 0;
    ring_pos = 0;
    last_average = 0;
    half_ext = '{0, 0, 0, 0};
    coefficient = longint'(signed'(COEF_RESET));
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    bar_if.valid = 1'b0;
    bar_if.close_price = '0;
    bar_if.low_price = '0;
    bar_if.high_price = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < $size(DIRECTED_BARS); i++)
      send_bar(DIRECTED_BARS[i].close_price, DIRECTED_BARS[i].low_price,
               DIRECTED_BARS[i].high_price, DIRECTED_BARS[i].typed,
               DIRECTED_BARS[i].avg, 1'b0);
    bar_if.valid <= 1'b0;
    mode = 0;
    base = 0;
    spread = 0;
    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      write_coefficient(coef_plan[ph]);
      for (int i = 0; i < RANDOM_BARS / 5; i++) begin
        // Runs of twenty bars share a shape: mostly a drifting market,
        // sometimes flat, inverted or plain noise.
        if (i % 20 == 0) begin
          mode = $urandom_range(9);
          base = $urandom();
          spread = 32'd1 << $urandom_range(24, 4);
        end
        calm = (i / 40) % 3 == 1;
        case (mode)
          0: begin
            c = $urandom();
            l = $urandom();
            h = $urandom();
          end
          1: begin
            c = base;
            l = base;
            h = base;
          end
          2: begin
            c = $urandom();
            h = $urandom();
            l = h + $urandom_range(spread);
          end
          default: begin
            base = base + $urandom_range(spread) - spread / 2;
            c = base;
            l = base - $urandom_range(spread);
            h = base + $urandom_range(spread);
            if (l > base) l = 0;
            if (h < base) h = 32'hFFFF_FFFF;
          end
        endcase
        send_bar(c, l, h, 1'b0, 32'h0, calm);
      end
      bar_if.valid <= 1'b0;
    end
    wait_idle();
    $display("Sent %0d bars under five coefficient settings, extremes included.", bars_sent);
    $display("Checked %0d averages, %0d of them held steady.", results_seen, held_seen);
    if (mismatches == 0 && pending_averages.size() == 0) begin
      $display("[fractal_adaptive_moving_average] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_averages.size());
      $display("[fractal_adaptive_moving_average] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
